// ===== design/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants for the range minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int NODE_COUNT_DEF   = 4096;
    localparam int VAL_W            = 32;
    localparam int IDX_W            = 10;
    localparam int CNT_W            = 11;
    localparam logic [VAL_W-1:0] LARGEST_INT = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // controller -> datapath
    typedef struct packed {
        logic start;      // latch item, reset walk
        logic descend;    // take one step down the update path
        logic rd_leaf;    // issue read of the leaf node
        logic wr_leaf;    // write the leaf, step up
        logic rd_kids;    // read both children of the current ancestor
        logic wr_up;      // write ancestor minimum, step up
        logic q_step;     // advance query stack machine by one phase
        logic rd_root;    // read root
        logic finish;     // capture result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic at_leaf;
        logic at_root;
        logic q_done;
        logic is_query;
        logic is_update;
        logic q_empty;
        logic clearing;
    } t_sts;
endpackage

// ===== design/rmst_if.sv =====
// ----------------------------------------------------------------------------
// rmst_if
// Valid/ready channel interfaces for items and results.
// ----------------------------------------------------------------------------
interface rmst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [9:0]  first_index;
    logic [9:0]  last_index;
    logic signed [31:0] operand_value;
    modport source (output valid, opcode, first_index, last_index, operand_value,
                    input ready);
    modport sink   (input valid, opcode, first_index, last_index, operand_value,
                    output ready);
endinterface

interface rmst_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] min_value;
    logic        range_empty;
    modport source (output valid, min_value, range_empty, input ready);
    modport sink   (input valid, min_value, range_empty, output ready);
endinterface

// ===== design/rmst_datapath.sv =====
// ----------------------------------------------------------------------------
// rmst_datapath
// Node memory, path walker and query traversal stack.
// ----------------------------------------------------------------------------
module rmst_datapath #(
    parameter int MAX_ELEMENTS = rmst_pkg::MAX_ELEMENTS_DEF,
    parameter int NODE_COUNT   = rmst_pkg::NODE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmst_pkg::t_cmd        i_cmd,
    output rmst_pkg::t_sts        o_sts,
    input  logic [10:0]           i_count,
    input  logic [1:0]            i_opcode,
    input  logic [9:0]            i_first,
    input  logic [9:0]            i_last,
    input  logic [31:0]           i_operand,
    output logic [31:0]           o_min,
    output logic                  o_empty
);
    import rmst_pkg::*;

    localparam int NW = $clog2(NODE_COUNT);
    localparam int EW = 17;          // element coordinates up to 131071
    localparam int NDW = EW + 2;     // node index, one bit beyond any child of a stored node
    localparam int SP_W = 5;
    localparam int STK_D = 32;       // deeper than any path plus one pending sibling

    logic [VAL_W-1:0] r_mem [NODE_COUNT];

    // zero the store once after reset, one node per cycle
    logic [NW-1:0] r_clr_idx;
    logic          r_clearing;

    logic [EW-1:0] r_n;            // used count minus one
    logic [1:0]    r_op;
    logic [EW-1:0] r_pos, r_hi;
    logic [VAL_W-1:0] r_val;
    logic [NDW-1:0] r_node;
    logic [EW-1:0] r_s, r_e;
    logic [VAL_W-1:0] r_rd_a, r_rd_b;
    logic [VAL_W-1:0] r_min, r_acc;
    logic          r_empty;

    // query stack
    logic [NDW-1:0] r_stk_node [STK_D];
    logic [EW-1:0] r_stk_s [STK_D];
    logic [EW-1:0] r_stk_e [STK_D];
    logic [SP_W:0] r_sp;
    logic          r_q_phase;

    logic [EW-1:0] n_cnt, w_mid;
    logic [NW-1:0] w_na, w_nb;
    logic          w_inb_a, w_inb_b;
    logic          w_we;
    logic [NW-1:0] w_wa;
    logic [VAL_W-1:0] w_wd;

    function automatic logic [VAL_W-1:0] smin(input logic [VAL_W-1:0] a, b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    always_comb begin
        if (i_count == '0)
            n_cnt = '0;
        else if (32'(i_count) > MAX_ELEMENTS)
            n_cnt = EW'(MAX_ELEMENTS - 1);
        else
            n_cnt = EW'(i_count) - 1'b1;
        w_mid = EW'(({1'b0, r_s} + {1'b0, r_e}) >> 1);
    end

    // memory read/write addresses
    always_comb begin
        w_na    = NW'(r_node);
        w_nb    = NW'(r_node);
        w_inb_a = 1'b1;
        w_inb_b = 1'b1;
        if (i_cmd.rd_kids) begin
            w_na    = NW'({r_node, 1'b0});
            w_nb    = NW'({r_node, 1'b1});
            w_inb_a = ({r_node, 1'b0} < (NDW+1)'(NODE_COUNT));
            w_inb_b = ({r_node, 1'b1} < (NDW+1)'(NODE_COUNT));
        end else if (i_cmd.rd_root) begin
            w_na    = NW'(1);
        end else begin
            w_inb_a = (r_node < NDW'(NODE_COUNT));
        end
    end

    // single write port
    always_comb begin
        w_we = 1'b0;
        w_wa = w_na;
        w_wd = smin(r_rd_a, r_rd_b);
        if (r_clearing) begin
            w_we = 1'b1;
            w_wa = r_clr_idx;
            w_wd = '0;
        end else if (i_cmd.wr_leaf) begin
            w_we = w_inb_a;
            w_wd = (r_op == OP_ADD) ? r_rd_a + r_val : r_val;
        end else if (i_cmd.wr_up) begin
            w_we = w_inb_a && ({r_node, 1'b1} < (NDW+1)'(NODE_COUNT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we)
            r_mem[w_wa] <= w_wd;
    end

    logic w_q_cover, w_q_out;
    logic [NDW-1:0] w_top_node;
    logic [EW-1:0] w_top_s, w_top_e;
    assign w_top_node = r_stk_node[r_sp[SP_W-1:0] - 1'b1];
    assign w_top_s    = r_stk_s[r_sp[SP_W-1:0] - 1'b1];
    assign w_top_e    = r_stk_e[r_sp[SP_W-1:0] - 1'b1];
    assign w_q_cover  = (r_pos <= w_top_s) && (w_top_e <= r_hi);
    assign w_q_out    = (r_hi < w_top_s) || (w_top_e < r_pos);

    logic [EW-1:0] w_tmid;
    assign w_tmid = EW'(({1'b0, w_top_s} + {1'b0, w_top_e}) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clearing <= 1'b1;
            r_sp       <= '0;
            r_q_phase  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == NW'(NODE_COUNT - 1))
                    r_clearing <= 1'b0;
            end
            if (i_cmd.start) begin
                r_n    <= n_cnt;
                r_op   <= i_opcode;
                r_pos  <= EW'(i_first);
                r_hi   <= (EW'(i_last) > n_cnt) ? n_cnt : EW'(i_last);
                r_val  <= i_operand;
                r_node <= NDW'(1);
                r_s    <= '0;
                r_e    <= n_cnt;
                r_acc  <= LARGEST_INT;
                r_sp   <= (SP_W+1)'(1);
                r_stk_node[0] <= NDW'(1);
                r_stk_s[0]    <= '0;
                r_stk_e[0]    <= n_cnt;
                r_q_phase <= 1'b0;
            end
            if (i_cmd.descend) begin
                if (r_pos <= w_mid) begin
                    r_node <= {r_node[NDW-2:0], 1'b0};
                    r_e    <= w_mid;
                end else begin
                    r_node <= {r_node[NDW-2:0], 1'b1};
                    r_s    <= w_mid + 1'b1;
                end
            end
            if (i_cmd.rd_leaf || i_cmd.rd_root)
                r_rd_a <= r_mem[w_na];
            if (i_cmd.rd_kids) begin
                r_rd_a <= !w_inb_a ? '0 : r_mem[w_na];
                r_rd_b <= !w_inb_b ? '0 : r_mem[w_nb];
            end
            if (i_cmd.wr_leaf || i_cmd.wr_up)
                r_node <= r_node >> 1;
            if (i_cmd.q_step && r_sp != '0) begin
                // phase 0: classify top; phase 1: use read data of a covered node
                if (!r_q_phase) begin
                    if (w_top_node >= NDW'(NODE_COUNT) || w_q_out) begin
                        r_sp <= r_sp - 1'b1;
                    end else if (w_q_cover) begin
                        r_rd_a    <= r_mem[NW'(w_top_node)];
                        r_q_phase <= 1'b1;
                    end else begin
                        // replace top with right child, push left child
                        r_stk_node[r_sp[SP_W-1:0] - 1'b1] <= {w_top_node[NDW-2:0], 1'b1};
                        r_stk_s[r_sp[SP_W-1:0] - 1'b1]    <= w_tmid + 1'b1;
                        r_stk_node[r_sp[SP_W-1:0]] <= {w_top_node[NDW-2:0], 1'b0};
                        r_stk_s[r_sp[SP_W-1:0]]    <= w_top_s;
                        r_stk_e[r_sp[SP_W-1:0]]    <= w_tmid;
                        r_sp <= r_sp + 1'b1;
                    end
                end else begin
                    r_acc     <= smin(r_acc, r_rd_a);
                    r_sp      <= r_sp - 1'b1;
                    r_q_phase <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                if (r_op == OP_QUERY) begin
                    r_empty <= (r_pos > r_hi);
                    r_min   <= (r_pos > r_hi) ? LARGEST_INT : r_acc;
                end else begin
                    r_empty <= 1'b0;
                    r_min   <= r_rd_a;
                end
            end
        end
    end

    assign o_sts.at_leaf   = (r_s == r_e) || (r_node >= NDW'(NODE_COUNT));
    assign o_sts.at_root   = (r_node == NDW'(1));
    assign o_sts.q_done    = (r_sp == '0);
    assign o_sts.is_query  = (r_op == OP_QUERY);
    assign o_sts.is_update = (r_op != OP_QUERY) && (r_op != OP_NONE) && (r_pos <= r_n);
    assign o_sts.q_empty   = (r_pos > r_hi);
    assign o_sts.clearing  = r_clearing;
    assign o_min   = r_min;
    assign o_empty = r_empty;
endmodule

// ===== design/rmst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer for load, add and query walks over the node memory.
// ----------------------------------------------------------------------------
module rmst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rmst_pkg::t_sts i_sts,
    output rmst_pkg::t_cmd o_cmd
);
    import rmst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_DOWN, S_LEAF_RD, S_LEAF_WR, S_UP_RD, S_UP_WR,
        S_QUERY, S_ROOT, S_DONE, S_OUT
    } t_state;

    t_state r_state;
    logic   w_take;

    // hold off items while the node store is being cleared
    assign w_take = (r_state == S_IDLE) && !i_sts.clearing && i_in_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.start   = w_take;
        o_cmd.descend = (r_state == S_DOWN) && !i_sts.at_leaf;
        o_cmd.rd_leaf = (r_state == S_LEAF_RD);
        o_cmd.wr_leaf = (r_state == S_LEAF_WR);
        o_cmd.rd_kids = (r_state == S_UP_RD);
        o_cmd.wr_up   = (r_state == S_UP_WR);
        o_cmd.q_step  = (r_state == S_QUERY);
        o_cmd.rd_root = (r_state == S_ROOT);
        o_cmd.finish  = (r_state == S_DONE);
    end

    assign o_in_ready  = (r_state == S_IDLE) && !i_sts.clearing;
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:    if (w_take) r_state <= S_DISP;
                S_DISP: begin
                    if (i_sts.is_query)
                        r_state <= i_sts.q_empty ? S_DONE : S_QUERY;
                    else if (i_sts.is_update)
                        r_state <= S_DOWN;
                    else
                        r_state <= S_ROOT;
                end
                S_DOWN:    if (i_sts.at_leaf) r_state <= S_LEAF_RD;
                S_LEAF_RD: r_state <= S_LEAF_WR;
                S_LEAF_WR: r_state <= i_sts.at_root ? S_ROOT : S_UP_RD;
                S_UP_RD:   r_state <= S_UP_WR;
                S_UP_WR:   r_state <= i_sts.at_root ? S_ROOT : S_UP_RD;
                S_QUERY:   if (i_sts.q_done) r_state <= S_DONE;
                S_ROOT:    r_state <= S_DONE;
                S_DONE:    r_state <= S_OUT;
                S_OUT:     if (i_out_ready) r_state <= S_IDLE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/range_min_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_min_segment_tree
// Minimum segment tree with load, add and range query over node memory.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in        in   valid/ready    opcode, first_index, last_index, operand_value
//  out       out  valid/ready    min_value, range_empty
//  cfg       in   APB write      element_count at address 0
//
//  After reset a clearing pass zeroes the node store (NODE_COUNT nodes, 4096 by
//  default), one node per cycle, with in_ch.ready held low.
//  Load/add: dispatch, one descend step per level down to the leaf, a leaf read
//  and write, then a child read and an ancestor write per level up, a root read.
//  Query: one stack step per visited node plus one per covered node.
//  One item at a time; the result register holds until taken, input waits.
module range_min_segment_tree #(
    parameter int MAX_ELEMENTS = rmst_pkg::MAX_ELEMENTS_DEF,
    parameter int NODE_COUNT   = rmst_pkg::NODE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmst_in_if.sink     in_ch,
    rmst_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rmst_pkg::*;

    logic [10:0] r_count;
    t_cmd w_cmd;
    t_sts w_sts;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {21'd0, r_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 11'd1024;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_count <= pwdata[10:0];
        end
    end

    rmst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rmst_datapath #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .NODE_COUNT  (NODE_COUNT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_count  (r_count),
        .i_opcode (in_ch.opcode),
        .i_first  (in_ch.first_index),
        .i_last   (in_ch.last_index),
        .i_operand(in_ch.operand_value),
        .o_min    (out_ch.min_value),
        .o_empty  (out_ch.range_empty)
    );
endmodule

// ===== design/rmst_checker.sv =====
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks on item and result ordering.
// ----------------------------------------------------------------------------
module rmst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] min_value,
    input logic        range_empty
);
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_value))
        else $error("result dropped");
    a_empty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && range_empty |-> min_value == 32'h7FFF_FFFF)
        else $error("empty range without largest int");
    a_no_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind range_min_segment_tree rmst_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .min_value  (out_ch.min_value),
    .range_empty(out_ch.range_empty)
);

// ===== test/range_min_segment_tree_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_min_segment_tree_tb
// Drives load, add, query and no-op transactions into the segment tree under several
// element counts, with random idling on both channels, and checks every
// result against a behavioral minimum tree kept in a scoreboard class.
// ----------------------------------------------------------------------------
import rmst_pkg::*;

class rmst_scoreboard;
    logic [31:0]  nodes [NODE_COUNT_DEF];
    int unsigned  count_reg;
    logic [31:0]  exp_min [$];
    logic         exp_empty [$];
    int           mismatches;
    int           checked;

    function new();
        foreach (nodes[k]) nodes[k] = '0;
        count_reg  = 1024;
        mismatches = 0;
        checked    = 0;
    endfunction

    function int unsigned used_count();
        if (count_reg < 1) return 1;
        if (count_reg > MAX_ELEMENTS_DEF) return MAX_ELEMENTS_DEF;
        return count_reg;
    endfunction

    function logic [31:0] smin(logic [31:0] a, logic [31:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function void update_leaf(int unsigned s, int unsigned e, int unsigned pos,
                              logic [31:0] val, bit is_add, int unsigned node);
        int unsigned m;
        if (node >= NODE_COUNT_DEF) return;
        if (s == e) begin
            nodes[node] = is_add ? nodes[node] + val : val;
            return;
        end
        m = (s + e) / 2;
        if (pos <= m) update_leaf(s, m, pos, val, is_add, 2 * node);
        else update_leaf(m + 1, e, pos, val, is_add, 2 * node + 1);
        if (2 * node + 1 < NODE_COUNT_DEF)
            nodes[node] = smin(nodes[2 * node], nodes[2 * node + 1]);
    endfunction

    function logic [31:0] span_min(int unsigned s, int unsigned e, int unsigned qs,
                                   int unsigned qe, int unsigned node);
        int unsigned m;
        if (node >= NODE_COUNT_DEF) return LARGEST_INT;
        if (qs <= s && e <= qe) return nodes[node];
        if (qe < s || e < qs) return LARGEST_INT;
        m = (s + e) / 2;
        return smin(span_min(s, m, qs, qe, 2 * node),
                    span_min(m + 1, e, qs, qe, 2 * node + 1));
    endfunction

    // Note an accepted transaction and queue its expected result.
    function void note_item(t_opcode op, int unsigned first, int unsigned last,
                            logic [31:0] val);
        int unsigned n, hi;
        n = used_count();
        if (op == OP_QUERY) begin
            hi = (last > n - 1) ? n - 1 : last;
            if (first > hi) begin
                exp_min.push_back(LARGEST_INT);
                exp_empty.push_back(1'b1);
            end else begin
                exp_min.push_back(span_min(0, n - 1, first, hi, 1));
                exp_empty.push_back(1'b0);
            end
        end else begin
            if (op != OP_NONE && first < n)
                update_leaf(0, n - 1, first, val, op == OP_ADD, 1);
            exp_min.push_back(nodes[1]);
            exp_empty.push_back(1'b0);
        end
    endfunction

    function void check_result(logic [31:0] got_min, logic got_empty);
        logic [31:0] em;
        logic        ee;
        checked++;
        if (exp_min.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result min=%0d empty=%0b",
                         $signed(got_min), got_empty);
            return;
        end
        em = exp_min.pop_front();
        ee = exp_empty.pop_front();
        if (got_min !== em || got_empty !== ee) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d: expected min=%0d empty=%0b, got min=%0d empty=%0b",
                         checked, $signed(em), ee, $signed(got_min), got_empty);
        end
    endfunction
endclass

module range_min_segment_tree_tb;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rmst_in_if  item_ch ();
    rmst_out_if res_ch ();

    range_min_segment_tree dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (item_ch.sink),
        .out_ch  (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rmst_scoreboard tree_sb = new();
    bit      idle_on = 1'b1;
    int      idle_cycles;
    int      n_load, n_add, n_query, n_empty;

    always #6 i_clk = ~i_clk;

    initial begin
        item_ch.valid = 1'b0;
        item_ch.opcode = '0;
        item_ch.first_index = '0;
        item_ch.last_index = '0;
        item_ch.operand_value = '0;
        res_ch.ready = 1'b0;
    end

    // Check results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            tree_sb.check_result(res_ch.min_value, res_ch.range_empty);
    end

    // Watchdog: cycles with no accepted transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: stall in random bursts.
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                res_ch.ready = 1'b0;
                gap = $urandom_range(1, 12);
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            @(negedge i_clk);
        end
    end

    task automatic cfg_write(input logic [1:0] addr, input logic [31:0] data);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        tree_sb.count_reg = data[10:0];
    endtask

    task automatic send_item(input t_opcode op, input int unsigned first,
                             input int unsigned last, input logic [31:0] val);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid = 1'b1;
        item_ch.opcode = op;
        item_ch.first_index = first[9:0];
        item_ch.last_index = last[9:0];
        item_ch.operand_value = val;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        tree_sb.note_item(op, first[9:0], last[9:0], val);
        case (op)
            OP_LOAD:  n_load++;
            OP_ADD:   n_add++;
            OP_QUERY: n_query++;
            default: ;
        endcase
        if (op == OP_QUERY && (first[9:0] > last[9:0])) n_empty++;
        @(negedge i_clk);
        item_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (tree_sb.exp_min.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Load the first elements of the current count, then mix operations.
    task automatic run_phase(input int unsigned count, input int items);
        int unsigned n, a, b;
        int r;
        n = (count < 1) ? 1 : (count > 1024 ? 1024 : count);
        for (int k = 0; k < n && k < 40; k++) send_item(OP_LOAD, k, $urandom, rand_val());
        for (int k = 0; k < items; k++) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(a, n - 1);
            r = $urandom_range(0, 99);
            if (r < 20)      send_item(OP_LOAD, a, $urandom, rand_val());
            else if (r < 40) send_item(OP_ADD, a, $urandom, rand_val());
            else if (r < 85) send_item(OP_QUERY, a, b, $urandom);
            else if (r < 90) send_item(OP_NONE, $urandom, $urandom, $urandom);
            else             send_item(t_opcode'($urandom_range(0, 2)), $urandom,
                                       $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: reset tree of zeros, extremes, wrap, empty and clipped ranges.
        send_item(OP_QUERY, 0, 1023, 32'h0);
        send_item(OP_LOAD, 0, 0, 32'h8000_0000);
        send_item(OP_LOAD, 1023, 1023, 32'h7FFF_FFFF);
        send_item(OP_ADD, 1023, 0, 32'h1);
        send_item(OP_ADD, 0, 0, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 0, 0, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 1023, 1023, 32'h0);
        send_item(OP_QUERY, 5, 4, 32'h0);
        send_item(OP_QUERY, 1023, 0, 32'h0);
        send_item(OP_NONE, 3, 3, 32'h1234_5678);
        send_item(OP_QUERY, 0, 1023, 32'h0);
        drain();
        cfg_write(2'd0, 32'd0);
        send_item(OP_LOAD, 0, 0, 32'hFFFF_FFFE);
        send_item(OP_LOAD, 1, 0, 32'h5);
        send_item(OP_ADD, 700, 0, 32'h5);
        send_item(OP_QUERY, 0, 1023, 32'h0);
        send_item(OP_QUERY, 1, 1023, 32'h0);
        drain();
        cfg_write(2'd0, 32'd5);
        send_item(OP_LOAD, 4, 0, 32'h10);
        send_item(OP_QUERY, 2, 900, 32'h0);
        send_item(OP_QUERY, 5, 9, 32'h0);
        drain();

        cfg_write(2'd0, 32'd1);    run_phase(1, 60);    drain();
        cfg_write(2'd0, 32'd2047); run_phase(1024, 250); drain();
        cfg_write(2'd0, $urandom_range(2, 40)); run_phase(tree_sb.count_reg, 250); drain();
        cfg_write(2'd0, $urandom_range(41, 300)); run_phase(tree_sb.count_reg, 120); drain();
        cfg_write(2'd0, 32'd7);    run_phase(7, 150);   drain();
        idle_on = 1'b0;
        cfg_write(2'd0, 32'd1024); run_phase(17, 100);  drain();

        $display("Covered %0d loads, %0d adds, %0d queries (%0d reversed) over six counts",
                 n_load, n_add, n_query, n_empty);
        $display("Results checked: %0d, mismatches: %0d", tree_sb.checked, tree_sb.mismatches);
        if (tree_sb.mismatches == 0 && tree_sb.exp_min.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
design/rmst_pkg.sv
design/rmst_if.sv
design/rmst_datapath.sv
design/rmst_ctrl.sv
design/range_min_segment_tree.sv
design/rmst_checker.sv
test/range_min_segment_tree_tb.sv
